// File: hdl/ppa_pkg.sv
// Shared types and constants for the per-pool page allocator.
package ppa_pkg;
	localparam int ADDR_W = 40;
	localparam int POOLS_DEF = 8;
	localparam int MAX_PAGES_DEF = 32768;
	localparam int STEAL_BATCH_DEF = 8;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam logic [ADDR_W-1:0] KEND_RST = 40'd2148532224;
	localparam logic [ADDR_W-1:0] PTOP_RST = 40'd2281701376;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	localparam logic KIND_FREE = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	localparam logic CFG_KEND = 1'b0;
	localparam logic CFG_PTOP = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_BOUNDS, S_FREE_CHK, S_FREE_OWN, S_POP_RD, S_POP_WT,
		S_SCAN, S_WALK_RD, S_WALK_WT, S_CUT_RD, S_CUT_WT, S_STEAL_FIN, S_OUT
	} state_t;
endpackage

// File: hdl/per_pool_page_allocator_top.sv
// Items: a bad free is rejected at the check; a free searches the pools for its owner;
// a local alloc pops its own pool's head; an empty alloc scans the other pools;
// a steal walks up to STEAL_BATCH links of another pool's list and cuts them off.
// One item is worked at a time; the block returns to idle as the result is registered,
// and takes the next beat there once no bounds rebuild is running.
// Reset empties all pool lists and loads the default bounds; a config write
// recomputes the bounds and empties every list.
module per_pool_page_allocator_top import ppa_pkg::*; #(
	parameter int POOLS = POOLS_DEF,
	parameter int MAX_PAGES = MAX_PAGES_DEF,
	parameter int STEAL_BATCH = STEAL_BATCH_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [2:0]        requester,
	input  logic [ADDR_W-1:0] page_address,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] granted_address,
	output logic [1:0]        status
);
	localparam int PW = $clog2(PAGE_BYTES);
	localparam int IW = $clog2(MAX_PAGES);
	localparam int HW = $clog2(MAX_PAGES + 1);
	localparam int QW = (POOLS > 1) ? $clog2(POOLS) : 1;
	localparam int BW = $clog2(STEAL_BATCH + 1);
	localparam int CW = ADDR_W - $clog2(POOLS);

	// configuration and derived bounds
	logic [ADDR_W-1:0] kend_q, ptop_q;
	logic [ADDR_W-1:0] bnd_q [POOLS+1];
	logic [HW-1:0]     head_q [POOLS];
	logic              rebuild_q;
	logic [QW:0]       bi_q;
	logic [ADDR_W-1:0] chunk_q, bacc_q;

	state_t st_q, st_d;
	logic              kind_q;
	logic [QW-1:0]     req_q, scan_q, own_q;
	logic [ADDR_W-1:0] pa_q;
	logic [HW-1:0]     first_q, last_q;
	logic [BW-1:0]     cnt_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [1:0]        res_st_q;
	logic              outv_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [1:0]        out_st_q;

	// link RAM
	logic          ram_we;
	logic [IW-1:0] ram_wa, ram_ra;
	logic [HW-1:0] ram_wd, ram_rd;

	ppa_ram #(.WIDTH(HW), .DEPTH(MAX_PAGES)) u_link (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic [QW-1:0] req_mod;
	assign req_mod = QW'(32'(requester) % POOLS);

	logic [ADDR_W-1:0] rel;
	logic              page_ok;
	assign rel = pa_q - bnd_q[0];
	assign page_ok = (pa_q[PW-1:0] == '0) && (pa_q >= kend_q) && (pa_q < ptop_q)
		&& (pa_q >= bnd_q[0]) && ((rel >> PW) < ADDR_W'(MAX_PAGES));

	logic [HW-1:0] pa_h;
	assign pa_h = HW'(rel >> PW) + HW'(1);

	logic [QW-1:0] scan_nx;
	assign scan_nx = (32'(scan_q) == POOLS - 1) ? '0 : scan_q + QW'(1);

	// owner check for the pool at scan_q
	logic in_pool;
	assign in_pool = (pa_q >= bnd_q[scan_q]) && (pa_q < bnd_q[32'(scan_q) + 1]);

	always_comb begin
		st_d = st_q;
		ram_we = 1'b0;
		ram_wa = '0;
		ram_wd = '0;
		ram_ra = '0;
		unique case (st_q)
			S_IDLE: if (in_valid && !rebuild_q) st_d = S_FREE_CHK;
			S_BOUNDS: st_d = S_IDLE;
			S_FREE_CHK: begin
				if (kind_q == KIND_ALLOC) begin
					st_d = (head_q[req_q] != '0) ? S_POP_RD : S_SCAN;
				end else begin
					st_d = page_ok ? S_FREE_OWN : S_OUT;
				end
			end
			S_FREE_OWN: begin
				if (in_pool || 32'(scan_q) == POOLS - 1) begin
					ram_we = 1'b1;
					ram_wa = IW'(pa_h - HW'(1));
					ram_wd = head_q[scan_q];
					st_d = S_OUT;
				end
			end
			S_POP_RD: begin
				ram_ra = IW'(head_q[req_q] - HW'(1));
				st_d = S_POP_WT;
			end
			S_POP_WT: st_d = S_OUT;
			S_SCAN: begin
				if (scan_q == req_q) st_d = S_OUT;
				else if (head_q[scan_q] != '0) st_d = S_WALK_RD;
			end
			S_WALK_RD: begin
				ram_ra = IW'(last_q - HW'(1));
				st_d = S_WALK_WT;
			end
			S_WALK_WT: begin
				if (32'(cnt_q) < STEAL_BATCH && ram_rd != '0) st_d = S_WALK_RD;
				else st_d = S_CUT_RD;
			end
			S_CUT_RD: begin
				ram_ra = IW'(first_q - HW'(1));
				ram_we = 1'b1;
				ram_wa = IW'(last_q - HW'(1));
				ram_wd = '0;
				st_d = S_CUT_WT;
			end
			S_CUT_WT: begin
				// keep the read on first so its link is re-read in the next state, after the cut write
				ram_ra = IW'(first_q - HW'(1));
				st_d = S_STEAL_FIN;
			end
			S_STEAL_FIN: st_d = S_OUT;
			S_OUT: if (!outv_q || out_ready) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	assign in_ready = (st_q == S_IDLE) && !rebuild_q;

	// link read after the final walk step, kept for the cut
	logic [HW-1:0] tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			kend_q <= KEND_RST;
			ptop_q <= PTOP_RST;
			rebuild_q <= 1'b1;
			bi_q <= '0;
			outv_q <= 1'b0;
			for (int i = 0; i < POOLS; i++) head_q[i] <= '0;
		end else begin
			st_q <= st_d;
			// output register: load a finished result, or drop a taken beat
			if (st_q == S_OUT && (!outv_q || out_ready)) begin
				outv_q <= 1'b1;
				out_addr_q <= res_addr_q;
				out_st_q <= res_st_q;
			end else if (outv_q && out_ready) begin
				outv_q <= 1'b0;
			end
			// configuration write starts a bounds rebuild
			if (cfg_we) begin
				if (cfg_index == CFG_KEND) kend_q <= cfg_data;
				else ptop_q <= cfg_data;
				rebuild_q <= 1'b1;
				bi_q <= '0;
			end else if (rebuild_q) begin
				if (bi_q == '0) begin
					chunk_q <= ((ptop_q > kend_q) ? ptop_q - kend_q : '0) / POOLS;
					bnd_q[0] <= ((kend_q + ADDR_W'(PAGE_BYTES - 1)) >> PW) << PW;
					bacc_q <= kend_q;
					bnd_q[POOLS] <= ptop_q;
					for (int i = 0; i < POOLS; i++) head_q[i] <= '0;
					bi_q <= bi_q + (QW+1)'(1);
				end else if (32'(bi_q) < POOLS) begin
					bnd_q[bi_q] <= ((bacc_q + chunk_q) >> PW) << PW;
					bacc_q <= bacc_q + chunk_q;
					bi_q <= bi_q + (QW+1)'(1);
				end else begin
					rebuild_q <= 1'b0;
				end
			end
			unique case (st_q)
				S_IDLE: if (in_valid && !rebuild_q) begin
					kind_q <= kind;
					req_q <= req_mod;
					pa_q <= page_address;
					scan_q <= '0;
				end
				S_FREE_CHK: begin
					if (kind_q == KIND_ALLOC) begin
						scan_q <= (32'(req_q) == POOLS - 1) ? '0 : req_q + QW'(1);
					end else if (!page_ok) begin
						res_addr_q <= '0;
						res_st_q <= ST_BAD;
					end
				end
				S_FREE_OWN: begin
					if (in_pool || 32'(scan_q) == POOLS - 1) begin
						head_q[scan_q] <= pa_h;
						res_addr_q <= '0;
						res_st_q <= ST_DONE;
					end else begin
						scan_q <= scan_nx;
					end
				end
				S_POP_WT: begin
					first_q <= head_q[req_q];
					head_q[req_q] <= ram_rd;
					res_st_q <= ST_DONE;
					res_addr_q <= bnd_q[0]
						+ (ADDR_W'(head_q[req_q] - HW'(1)) << PW);
				end
				S_SCAN: begin
					if (scan_q == req_q) begin
						res_addr_q <= '0;
						res_st_q <= ST_EMPTY;
					end else if (head_q[scan_q] != '0) begin
						first_q <= head_q[scan_q];
						last_q <= head_q[scan_q];
						cnt_q <= BW'(1);
					end else begin
						scan_q <= scan_nx;
					end
				end
				S_WALK_WT: begin
					tail_q <= ram_rd;
					if (32'(cnt_q) < STEAL_BATCH && ram_rd != '0) begin
						last_q <= ram_rd;
						cnt_q <= cnt_q + BW'(1);
					end
				end
				S_CUT_WT: begin
					head_q[scan_q] <= tail_q;
				end
				S_STEAL_FIN: begin
					// first's link re-read after the cut, so a batch of one yields 0
					head_q[req_q] <= (first_q == last_q) ? '0 : ram_rd;
					res_st_q <= ST_DONE;
					res_addr_q <= bnd_q[0] + (ADDR_W'(first_q - HW'(1)) << PW);
				end
				default: ;
			endcase
		end
	end

	assign out_valid = outv_q;
	assign granted_address = out_addr_q;
	assign status = out_st_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !in_ready) else $error("accept while busy");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3)) else $error("bad status code");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DONE) |-> (granted_address == '0))
		else $error("failed item carries an address");
endmodule

// File: hdl/ppa_ram.sv
// Generic single-port-write, registered-read RAM.
module ppa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
